// ===== rtl/sdte_pkg.sv =====
// shared types, character codes and the segment pattern rom for the text encoder
package sdte_pkg;

    // character codes
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOW_A   = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z   = 8'h7A;
    localparam logic [7:0] CHAR_UP_A    = 8'h41;
    localparam logic [7:0] CHAR_UP_Z    = 8'h5A;
    localparam logic [7:0] CHAR_POINT   = 8'h2E;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;

    // rom layout: ten digits, 26 letters, then the dash
    localparam int unsigned ROM_LETTER_BASE = 10;
    localparam int unsigned ROM_DASH        = 10 + 26 + 0;
    localparam int unsigned ROM_DEPTH       = 10 + 26 + 1;

    localparam int unsigned PAT_W = 11;
    localparam int unsigned CODE_W = $clog2(ROM_DEPTH);

    // decimal point sits in bit 2 of the high segment bits
    localparam logic [PAT_W-1:0] POINT_MASK = PAT_W'(32'h04 << 8);

    // input and output words
    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } t_in_word;

    typedef struct packed {
        logic [2:0] digit_position;
        logic [7:0] pattern_low;
        logic [2:0] pattern_high;
        logic       last_of_run;
    } t_out_word;

    // decoded character
    typedef struct packed {
        logic             push;
        logic             set_point;
        logic             is_digit;
        logic [PAT_W-1:0] pattern;
    } t_dec;

    // per-cycle control shared by every cell
    typedef struct packed {
        logic take;
        logic push;
        logic capture;
        logic drain;
    } t_cell_ctl;

    // segment patterns, {high bits, low byte}
    function automatic logic [PAT_W-1:0] seg_rom(input logic [CODE_W-1:0] code);
        logic [PAT_W-1:0] pat;
        unique case (code)
            6'd0:    pat = 11'h1F8;
            6'd1:    pat = 11'h030;
            6'd2:    pat = 11'h2D8;
            6'd3:    pat = 11'h278;
            6'd4:    pat = 11'h330;
            6'd5:    pat = 11'h368;
            6'd6:    pat = 11'h3E8;
            6'd7:    pat = 11'h038;
            6'd8:    pat = 11'h3F8;
            6'd9:    pat = 11'h378;
            6'd10:   pat = 11'h3B8;
            6'd11:   pat = 11'h3E0;
            6'd12:   pat = 11'h1C8;
            6'd13:   pat = 11'h2F0;
            6'd14:   pat = 11'h3C8;
            6'd15:   pat = 11'h388;
            6'd16:   pat = 11'h1E8;
            6'd17:   pat = 11'h3B0;
            6'd18:   pat = 11'h020;
            6'd19:   pat = 11'h070;
            6'd20:   pat = 11'h3D0;
            6'd21:   pat = 11'h1C0;
            6'd22:   pat = 11'h2A8;
            6'd23:   pat = 11'h2A0;
            6'd24:   pat = 11'h2E0;
            6'd25:   pat = 11'h398;
            6'd26:   pat = 11'h338;
            6'd27:   pat = 11'h280;
            6'd28:   pat = 11'h320;
            6'd29:   pat = 11'h3C0;
            6'd30:   pat = 11'h1F0;
            6'd31:   pat = 11'h310;
            6'd32:   pat = 11'h350;
            6'd33:   pat = 11'h1B0;
            6'd34:   pat = 11'h370;
            6'd35:   pat = 11'h248;
            6'd36:   pat = 11'h200;
            default: pat = '0;
        endcase
        return pat;
    endfunction

endpackage

// ===== rtl/sdte_decode.sv =====
// character classifier and rom lookup for one incoming word
module sdte_decode (
    input  logic [7:0]    i_char,
    input  logic          i_prev_digit,
    output sdte_pkg::t_dec o_dec
);
    import sdte_pkg::*;

    logic                is_digit;
    logic                is_lower;
    logic                is_upper;
    logic                is_dash;
    logic [7:0]          offset;
    logic [CODE_W-1:0]   code;

    // classify
    assign is_digit = (i_char >= CHAR_ZERO)  && (i_char <= CHAR_NINE);
    assign is_lower = (i_char >= CHAR_LOW_A) && (i_char <= CHAR_LOW_Z);
    assign is_upper = (i_char >= CHAR_UP_A)  && (i_char <= CHAR_UP_Z);
    assign is_dash  = (i_char == CHAR_DASH);

    // rom code from the character
    always_comb begin
        if (is_digit) begin
            offset = i_char - CHAR_ZERO;
        end else if (is_lower) begin
            offset = i_char - CHAR_LOW_A + 8'(ROM_LETTER_BASE);
        end else if (is_upper) begin
            offset = i_char - CHAR_UP_A + 8'(ROM_LETTER_BASE);
        end else begin
            offset = 8'(ROM_DASH);
        end
        code = offset[CODE_W-1:0];
    end

    assign o_dec.push      = is_digit | is_lower | is_upper | is_dash;
    assign o_dec.set_point = (i_char == CHAR_POINT) & i_prev_digit;
    assign o_dec.is_digit  = is_digit;
    assign o_dec.pattern   = seg_rom(code);

endmodule

// ===== rtl/sdte_cell.sv =====
// one display position: working pattern plus its slot in the drain chain
module sdte_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sdte_pkg::t_cell_ctl          i_ctl,
    input  logic                         i_set_point,
    input  logic [sdte_pkg::PAT_W-1:0]   i_right_pat,
    input  logic [sdte_pkg::PAT_W-1:0]   i_right_out,
    output logic [sdte_pkg::PAT_W-1:0]   o_pat,
    output logic [sdte_pkg::PAT_W-1:0]   o_out
);
    import sdte_pkg::*;

    logic [PAT_W-1:0] r_pat;
    logic [PAT_W-1:0] r_out;
    logic [PAT_W-1:0] n_pat;

    // value after the accepted character is applied
    always_comb begin
        n_pat = i_ctl.push ? i_right_pat : r_pat;
        if (i_set_point) begin
            n_pat = n_pat | POINT_MASK;
        end
    end

    // working pattern, cleared once a string ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat <= '0;
        end else if (i_ctl.take) begin
            r_pat <= i_ctl.capture ? '0 : n_pat;
        end
    end

    // drain slot: load the finished string, then shift toward position one
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_out <= n_pat;
        end else if (i_ctl.drain) begin
            r_out <= i_right_out;
        end
    end

    assign o_pat = r_pat;
    assign o_out = r_out;

endmodule

// ===== rtl/segment_display_text_encoder.sv =====
// top level of the seven-segment text encoder: decoder, cell row and drain control
//
//  channel  | direction | handshake                | word
//  ---------+-----------+--------------------------+----------------------------
//  in       | input     | i_in_valid / o_in_stall   | text_char, end_of_text
//  out      | output    | o_out_valid / i_out_stall | position, pattern, last flag
//
//  one character is taken per cycle unless an end word stalls; its pattern shifts
//  into the cell row from the right; an end word loads the row into the drain
//  chain, which gives DIGIT_COUNT words, one per cycle unless the receiver stalls
//  an end word stalls only while an earlier string is still draining
//  plain characters are never stalled; synchronous reset blanks the working patterns
module segment_display_text_encoder #(
    parameter int unsigned DIGIT_COUNT = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sdte_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sdte_pkg::t_out_word o_out_word
);
    import sdte_pkg::*;

    localparam int unsigned CW = $clog2(DIGIT_COUNT + 1);

    logic              r_prev_digit;
    logic [CW-1:0]     r_left;
    logic [2:0]        r_pos;
    t_dec              dec;
    t_cell_ctl         ctl;
    logic              drain_free;
    logic [PAT_W-1:0]  w_pat [DIGIT_COUNT];
    logic [PAT_W-1:0]  w_out [DIGIT_COUNT];

    // character decode
    sdte_decode u_decode (
        .i_char       (i_in_word.text_char),
        .i_prev_digit (r_prev_digit),
        .o_dec        (dec)
    );

    // handshake and cell control
    assign drain_free  = (r_left == '0) || ((r_left == CW'(1)) && !i_out_stall);
    assign o_in_stall  = i_in_valid && i_in_word.end_of_text && !drain_free;
    assign o_out_valid = (r_left != '0);

    assign ctl.take    = i_in_valid && !o_in_stall;
    assign ctl.push    = dec.push;
    assign ctl.capture = ctl.take && i_in_word.end_of_text;
    assign ctl.drain   = o_out_valid && !i_out_stall;

    // row of cells, position one on the left
    for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_cell
        logic [PAT_W-1:0] right_pat;
        logic [PAT_W-1:0] right_out;
        logic             set_point;

        if (k == DIGIT_COUNT - 1) begin : g_edge
            assign right_pat = dec.pattern;
            assign right_out = '0;
            assign set_point = dec.set_point;
        end else begin : g_inner
            assign right_pat = w_pat[k+1];
            assign right_out = w_out[k+1];
            assign set_point = 1'b0;
        end

        sdte_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_set_point (set_point),
            .i_right_pat (right_pat),
            .i_right_out (right_out),
            .o_pat       (w_pat[k]),
            .o_out       (w_out[k])
        );
    end

    // digit tracking for the decimal point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_digit <= 1'b0;
        end else if (ctl.take) begin
            r_prev_digit <= dec.is_digit && !i_in_word.end_of_text;
        end
    end

    // drain count and position number
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_pos  <= 3'd1;
        end else if (ctl.capture) begin
            r_left <= CW'(DIGIT_COUNT);
            r_pos  <= 3'd1;
        end else if (ctl.drain) begin
            r_left <= r_left - CW'(1);
            r_pos  <= r_pos + 3'd1;
        end
    end

    // output word
    assign o_out_word.digit_position = r_pos;
    assign o_out_word.pattern_low    = w_out[0][7:0];
    assign o_out_word.pattern_high   = w_out[0][PAT_W-1:8];
    assign o_out_word.last_of_run    = (r_left == CW'(1));

    // a captured string always starts a full run at position one
    a_capture_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.capture |=> (r_left == CW'(DIGIT_COUNT)) && (r_pos == 3'd1))
        else $error("run did not restart after capture");

    // once the last word leaves, nothing follows unless a new string was captured
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.drain && o_out_word.last_of_run && !ctl.capture) |=> !o_out_valid)
        else $error("output valid after the last word of a run");

    // only end words are ever held back
    a_stall_end_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> i_in_word.end_of_text)
        else $error("plain character stalled");

    // a capture never overruns a run still draining
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.capture |-> (r_left == '0) || (ctl.drain && o_out_word.last_of_run))
        else $error("capture while a run is still draining");

endmodule

// ===== tb/segment_display_text_encoder_tb.sv =====
// seven-segment encoder testbench: directed and random strings checked against a row predictor
`timescale 1ns / 1ps

module segment_display_text_encoder_tb;
    import sdte_pkg::*;

    localparam int unsigned ROW_SIZE    = 4;
    localparam int unsigned ITEM_TARGET = 480;
    localparam int unsigned QUIET_FROM  = 400;
    localparam logic [10:0] DOT_BIT     = 11'h400;

    // segment patterns, {high bits, low byte}: digits, letters, dash
    localparam logic [10:0] SEGMENTS [0:36] = '{
        11'h1F8, 11'h030, 11'h2D8, 11'h278, 11'h330, 11'h368, 11'h3E8, 11'h038,
        11'h3F8, 11'h378, 11'h3B8, 11'h3E0, 11'h1C8, 11'h2F0, 11'h3C8, 11'h388,
        11'h1E8, 11'h3B0, 11'h020, 11'h070, 11'h3D0, 11'h1C0, 11'h2A8, 11'h2A0,
        11'h2E0, 11'h398, 11'h338, 11'h280, 11'h320, 11'h3C0, 11'h1F0, 11'h310,
        11'h350, 11'h1B0, 11'h370, 11'h248, 11'h200
    };

    // predicted display row and the position words it still owes
    class segment_row_checker;
        logic [10:0] shown [ROW_SIZE];
        bit          after_digit;
        t_out_word   due_positions [$];
        int unsigned errors;

        function new();
            clear_row();
            errors = 0;
        endfunction

        function void clear_row();
            foreach (shown[k]) shown[k] = '0;
            after_digit = 1'b0;
        endfunction

        function void shift_in(int unsigned code);
            for (int k = 0; k + 1 < ROW_SIZE; k++) shown[k] = shown[k + 1];
            shown[ROW_SIZE - 1] = SEGMENTS[code];
        endfunction

        // note one accepted input word
        function void take_char(t_in_word w);
            t_out_word  pos;
            logic [7:0] c;
            c = w.text_char;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                shift_in(c - CHAR_ZERO);
                after_digit = 1'b1;
            end else begin
                // a point only counts right after a digit
                if (c == CHAR_POINT && after_digit)
                    shown[ROW_SIZE - 1] |= DOT_BIT;
                else if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z)
                    shift_in(ROM_LETTER_BASE + (c - CHAR_LOW_A));
                else if (c >= CHAR_UP_A && c <= CHAR_UP_Z)
                    shift_in(ROM_LETTER_BASE + (c - CHAR_UP_A));
                else if (c == CHAR_DASH)
                    shift_in(ROM_DASH);
                after_digit = 1'b0;
            end
            // end of text: one word per position, leftmost first, then blank the row
            if (w.end_of_text) begin
                for (int k = 0; k < ROW_SIZE; k++) begin
                    pos.digit_position = 3'(k + 1);
                    pos.pattern_low    = shown[k][7:0];
                    pos.pattern_high   = shown[k][10:8];
                    pos.last_of_run    = (k == ROW_SIZE - 1);
                    due_positions.push_back(pos);
                end
                clear_row();
            end
        endfunction

        // compare one accepted output word with the oldest expectation
        function void compare_position(t_out_word got);
            t_out_word want;
            if (due_positions.size() == 0) begin
                $error("output word %h with no expectation waiting", got);
                errors++;
                return;
            end
            want = due_positions.pop_front();
            if (got.digit_position !== want.digit_position) begin
                $error("digit_position: expected %0d, actual %0d",
                       want.digit_position, got.digit_position);
                errors++;
            end
            if (got.pattern_low !== want.pattern_low) begin
                $error("pattern_low: expected %h, actual %h", want.pattern_low, got.pattern_low);
                errors++;
            end
            if (got.pattern_high !== want.pattern_high) begin
                $error("pattern_high: expected %h, actual %h",
                       want.pattern_high, got.pattern_high);
                errors++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0d, actual %0d", want.last_of_run, got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_word;

    segment_row_checker row_chk = new();
    bit          idle_on = 1'b0;
    bit          drained_once = 1'b0;
    int unsigned chars_taken = 0;

    segment_display_text_encoder #(
        .DIGIT_COUNT(ROW_SIZE)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // drive one word and hold it until accepted, then maybe leave a gap
    task automatic send_char(input logic [7:0] c, input bit last);
        t_in_word w;
        w.text_char   = c;
        w.end_of_text = last;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        row_chk.take_char(w);
        chars_taken++;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    // mostly display text with random content, sometimes raw byte noise
    task automatic send_random_string();
        int unsigned len;
        int unsigned roll;
        logic [7:0]  c;
        bit          noisy;
        noisy = ($urandom_range(0, 4) == 0);
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
            roll = noisy ? 99 : $urandom_range(0, 99);
            if (roll < 40)      c = CHAR_ZERO + 8'($urandom_range(0, 9));
            else if (roll < 55) c = CHAR_LOW_A + 8'($urandom_range(0, 25));
            else if (roll < 70) c = CHAR_UP_A + 8'($urandom_range(0, 25));
            else if (roll < 80) c = CHAR_DASH;
            else if (roll < 95) c = CHAR_POINT;
            else                c = 8'($urandom_range(0, 255));
            send_char(c, i == len - 1);
        end
    endtask

    // receiver stalls in random bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // output word check
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) row_chk.compare_position(o_out_word);
    end

    // stimulus and end of run
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_out_stall <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        // directed strings: short, repeated points, leading point, both letter cases,
        // long string, point then letter, trailing point, nul and unknown end words
        send_text("8");
        send_text("1..");
        send_text(".5-");
        send_text("aZAz");
        send_text("0123456");
        send_text("9.Z");
        send_text("7.");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);

        while (chars_taken < ITEM_TARGET) begin
            if (chars_taken >= QUIET_FROM)
                idle_on = 1'b0;
            else
                idle_on = !(chars_taken >= 150 && chars_taken < 200);
            send_random_string();
            // hold off once until the block has drained everything
            if (!drained_once && chars_taken >= ITEM_TARGET / 2) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (row_chk.due_positions.size() != 0);
                drained_once = 1'b1;
            end
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (row_chk.due_positions.size() != 0);
        repeat (2 * ROW_SIZE + 8) @(posedge i_clk);
        if (row_chk.errors == 0 && row_chk.due_positions.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // timeout
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
